// ===== hw/rtl/occupation_rank_unrank_top_macros.svh =====
// ----------------------------------------------------------------------------
// occupation_rank_unrank_top_macros
// Assertion macros shared by the checker of the occupation rank/unrank block.
// ----------------------------------------------------------------------------
`ifndef OCCUPATION_RANK_UNRANK_TOP_MACROS_SVH
`define OCCUPATION_RANK_UNRANK_TOP_MACROS_SVH

// implication in the same cycle, held off during reset
`define ORU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("oru assertion failed");

// implication into the next cycle, held off during reset
`define ORU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("oru assertion failed");

// implication into the next cycle, checked in reset too
`define ORU_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("oru assertion failed");

`endif

// ===== hw/rtl/oru_pkg.sv =====
// ----------------------------------------------------------------------------
// oru_pkg
// Types and constants of the occupation rank/unrank block.
// ----------------------------------------------------------------------------
`default_nettype none
package oru_pkg;

    localparam int MAX_ORBS_DEF  = 16;
    localparam int MAX_PARTS_DEF = 32;

    localparam logic [31:0] DIM_SAT = 32'hFFFF_FFFF;

    localparam logic CMD_RANK   = 1'b0;
    localparam logic CMD_UNRANK = 1'b1;

    localparam logic REG_NUM_PARTICLES = 1'b0;
    localparam logic REG_NUM_ORBITALS  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SUM   = 2'd2;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_DISPATCH,
        S_RK_LOOP,
        S_RK_ADD,
        S_RK_FIN,
        S_UN_TOT,
        S_UN_ORB,
        S_UN_CHK,
        S_UN_EMIT
    } t_state;

    typedef struct packed {
        logic fill;
        logic accept;
        logic rk_begin;
        logic rk_set_err;
        logic rk_next;
        logic rd_en;
        logic rd_total;
        logic rk_add;
        logic unr_begin;
        logic unr_check_total;
        logic unr_sub;
        logic unr_next;
        logic emit;
        logic end_run;
    } t_cmd;

    typedef struct packed {
        logic fill_done;
        logic is_unrank;
        logic m_zero;
        logic cnt_eq_occ;
        logic rem_zero;
        logic bad;
        logic step_stop;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic       we;
        logic       idx;
        logic [5:0] data;
    } t_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/occupation_rank_unrank_top.sv =====
// ----------------------------------------------------------------------------
// occupation_rank_unrank_top
// Ranks and unranks bosonic occupation vectors through a dimension table.
// ----------------------------------------------------------------------------
// After reset the dimension table is built one entry a cycle; no request is
// taken meanwhile. A rank request does one table read and one add for every
// particle of its orbital; the request for the last orbital does no reads and
// writes the result. For each orbital the unrank decode walks the table, one
// read and compare per particle. The table has a single port with a registered
// read; one request is in work at a time.
`default_nettype none
module occupation_rank_unrank_top import oru_pkg::*; #(
    parameter int MAX_ORBS  = MAX_ORBS_DEF,
    parameter int MAX_PARTS = MAX_PARTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_cmd,
    input  wire  [5:0]  i_occupancy,
    input  wire  [31:0] i_index,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [5:0]  o_occ_out,
    output logic [31:0] o_index_out,
    output logic        o_last,
    output logic [1:0]  o_status
);

    t_cmd cmd;
    t_sts sts;
    t_cfg cfg;

    always_comb begin
        o_pready = 1'b1;
        cfg.we   = i_psel && i_penable && i_pwrite;
        cfg.idx  = i_paddr[2];
        cfg.data = i_pwdata[5:0];
    end

    oru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_stall)
    );

    oru_dpath #(
        .MAX_ORBS  (MAX_ORBS),
        .MAX_PARTS (MAX_PARTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_cmd_bit   (i_cmd),
        .i_occupancy (i_occupancy),
        .i_index     (i_index),
        .i_stall     (i_stall),
        .o_sts       (sts),
        .o_prdata    (o_prdata),
        .o_valid     (o_valid),
        .o_occ_out   (o_occ_out),
        .o_index_out (o_index_out),
        .o_last      (o_last),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/oru_ctrl.sv =====
// ----------------------------------------------------------------------------
// oru_ctrl
// Sequencer of table fill, rank steps and unrank steps.
// ----------------------------------------------------------------------------
`default_nettype none
module oru_ctrl import oru_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_unrank) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_total  = 1'b1;
                    o_cmd.unr_begin = 1'b1;
                    n_state         = S_UN_TOT;
                end else begin
                    o_cmd.rk_begin = 1'b1;
                    n_state        = S_RK_LOOP;
                end
            end
            S_RK_LOOP: begin
                if (i_sts.m_zero) begin
                    n_state = S_RK_FIN;
                end else if (i_sts.cnt_eq_occ) begin
                    o_cmd.rk_next = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_sts.rem_zero) begin
                    o_cmd.rk_set_err = 1'b1;
                    o_cmd.rk_next    = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_RK_ADD;
                end
            end
            S_RK_ADD: begin
                o_cmd.rk_add = 1'b1;
                n_state      = S_RK_LOOP;
            end
            S_RK_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.end_run = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_UN_TOT: begin
                o_cmd.unr_check_total = 1'b1;
                n_state               = S_UN_ORB;
            end
            S_UN_ORB: begin
                if (i_sts.bad || i_sts.m_zero || i_sts.rem_zero) begin
                    n_state = S_UN_EMIT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_UN_CHK;
                end
            end
            S_UN_CHK: begin
                if (i_sts.step_stop) begin
                    n_state = S_UN_EMIT;
                end else begin
                    o_cmd.unr_sub = 1'b1;
                    n_state       = S_UN_ORB;
                end
            end
            S_UN_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.m_zero) begin
                        o_cmd.end_run = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.unr_next = 1'b1;
                        n_state        = S_UN_ORB;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/oru_dpath.sv =====
// ----------------------------------------------------------------------------
// oru_dpath
// Dimension table, run registers, configuration and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module oru_dpath import oru_pkg::*; #(
    parameter int MAX_ORBS  = MAX_ORBS_DEF,
    parameter int MAX_PARTS = MAX_PARTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    input  t_cfg        i_cfg,
    input  wire         i_cmd_bit,
    input  wire  [5:0]  i_occupancy,
    input  wire  [31:0] i_index,
    input  wire         i_stall,
    output t_sts        o_sts,
    output logic [31:0] o_prdata,
    output logic        o_valid,
    output logic [5:0]  o_occ_out,
    output logic [31:0] o_index_out,
    output logic        o_last,
    output logic [1:0]  o_status
);

    localparam int TAB_COLS = MAX_ORBS + 1;
    localparam int DEPTH    = (MAX_PARTS + 1) * TAB_COLS;
    localparam int AW       = $clog2(DEPTH);
    localparam int PW       = $clog2(MAX_PARTS + 1) > 0 ? $clog2(MAX_PARTS + 1) : 1;
    localparam int FMW      = $clog2(MAX_ORBS + 1);
    localparam logic [5:0] MP6 = 6'(MAX_PARTS);
    localparam logic [5:0] MO6 = 6'(MAX_ORBS);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_row [TAB_COLS];
    logic [31:0] r_left;
    logic [31:0] r_rd;
    logic [PW-1:0]  r_fn;
    logic [FMW-1:0] r_fm;
    logic [AW-1:0]  r_fa;
    logic        r_fdone;

    logic [5:0]  r_par;
    logic [4:0]  r_orb;
    logic [5:0]  r_rem;
    logic [4:0]  r_oc;
    logic [31:0] r_ri;
    logic        r_err;
    logic        r_bad;
    logic [4:0]  r_m;
    logic [5:0]  r_cnt;
    logic [5:0]  r_occ;
    logic [31:0] r_hash;
    logic        r_cmd;

    logic        r_ovalid;
    logic [5:0]  r_oocc;
    logic [31:0] r_oidx;
    logic        r_olast;
    logic [1:0]  r_ostat;

    logic [5:0]  eff_par;
    logic [4:0]  eff_orb;
    logic [4:0]  oc_c;
    logic [32:0] fill_sum;
    logic [31:0] fill_v;
    logic [5:0]  rd_n;
    logic [4:0]  rd_m;
    logic [AW-1:0] rd_addr;
    logic [32:0] rk_sum;
    logic        fin_err;

    always_comb begin
        eff_par = (r_par > MP6) ? MP6 : r_par;
        if (r_orb == 5'd0) begin
            eff_orb = 5'd1;
        end else if ({1'b0, r_orb} > MO6) begin
            eff_orb = 5'(MAX_ORBS);
        end else begin
            eff_orb = r_orb;
        end
        oc_c     = (r_oc >= eff_orb) ? eff_orb - 5'd1 : r_oc;
        fill_sum = {1'b0, r_row[0]} + {1'b0, r_left};
        if (r_fm == '0) begin
            fill_v = 32'd0;
        end else if (r_fn == '0 || r_fm == FMW'(1)) begin
            fill_v = 32'd1;
        end else begin
            fill_v = fill_sum[32] ? DIM_SAT : fill_sum[31:0];
        end
        rd_n    = i_cmd.rd_total ? eff_par : r_rem;
        rd_m    = i_cmd.rd_total ? eff_orb : r_m;
        rd_addr = AW'(32'(rd_n) * 32'(TAB_COLS) + 32'(rd_m));
        rk_sum  = {1'b0, r_ri} + {1'b0, r_rd};
        fin_err = r_err || (r_occ != r_rem);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill && !r_fdone) begin
            mem[r_fa] <= fill_v;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill && !r_fdone) begin
            for (int i = 0; i < TAB_COLS - 1; i++) begin
                r_row[i] <= r_row[i+1];
            end
            r_row[TAB_COLS-1] <= fill_v;
            r_left            <= fill_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn    <= '0;
            r_fm    <= '0;
            r_fa    <= '0;
            r_fdone <= 1'b0;
        end else if (i_cmd.fill && !r_fdone) begin
            r_fa <= r_fa + AW'(1);
            if (r_fm == FMW'(MAX_ORBS)) begin
                r_fm <= '0;
                if (r_fn == PW'(MAX_PARTS)) begin
                    r_fdone <= 1'b1;
                end else begin
                    r_fn <= r_fn + PW'(1);
                end
            end else begin
                r_fm <= r_fm + FMW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_cmd_bit;
            r_occ  <= i_occupancy;
            r_hash <= i_index;
        end
        if (i_cmd.rk_begin) begin
            r_m   <= eff_orb - 5'd1 - oc_c;
            r_cnt <= 6'd0;
        end
        if (i_cmd.rk_add) begin
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.unr_begin) begin
            r_m   <= eff_orb - 5'd1;
            r_cnt <= 6'd0;
        end
        if (i_cmd.unr_sub) begin
            r_hash <= r_hash - r_rd;
            r_cnt  <= r_cnt + 6'd1;
        end
        if (i_cmd.unr_next) begin
            r_m   <= r_m - 5'd1;
            r_cnt <= 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par <= 6'd1;
            r_orb <= 5'd1;
            r_rem <= '0;
            r_oc  <= '0;
            r_ri  <= '0;
            r_err <= 1'b0;
            r_bad <= 1'b0;
        end else begin
            if (i_cmd.rk_begin) begin
                r_oc <= oc_c;
                if (r_oc == 5'd0) begin
                    r_rem <= eff_par;
                    r_ri  <= '0;
                    r_err <= 1'b0;
                end
            end
            if (i_cmd.rk_set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.rk_next) begin
                r_oc <= r_oc + 5'd1;
            end
            if (i_cmd.rk_add) begin
                r_rem <= r_rem - 6'd1;
                if (r_rd == DIM_SAT || rk_sum[32]) begin
                    r_err <= 1'b1;
                end else if (!r_err) begin
                    r_ri <= rk_sum[31:0];
                end
            end
            if (i_cmd.unr_begin) begin
                r_rem <= eff_par;
                r_bad <= 1'b0;
            end
            if (i_cmd.unr_check_total) begin
                r_bad <= !(r_hash < r_rd || r_rd == DIM_SAT);
            end
            if (i_cmd.unr_sub) begin
                r_rem <= r_rem - 6'd1;
            end
            if (i_cmd.end_run) begin
                r_rem <= '0;
                r_oc  <= '0;
                r_ri  <= '0;
                r_err <= 1'b0;
                r_bad <= 1'b0;
            end
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    REG_NUM_PARTICLES: r_par <= i_cfg.data;
                    REG_NUM_ORBITALS:  r_orb <= i_cfg.data[4:0];
                    default:           r_par <= r_par;
                endcase
                r_rem <= '0;
                r_oc  <= '0;
                r_ri  <= '0;
                r_err <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_cmd == CMD_RANK) begin
                r_oocc  <= 6'd0;
                r_oidx  <= fin_err ? 32'd0 : r_ri;
                r_olast <= 1'b1;
                r_ostat <= fin_err ? ST_SUM : ST_OK;
            end else begin
                r_oidx  <= 32'd0;
                r_olast <= (r_m == 5'd0);
                if (r_bad) begin
                    r_oocc  <= 6'd0;
                    r_ostat <= ST_RANGE;
                end else begin
                    r_oocc  <= (r_m == 5'd0) ? r_rem : r_cnt;
                    r_ostat <= ST_OK;
                end
            end
        end
    end

    always_comb begin
        o_sts.fill_done  = r_fdone;
        o_sts.is_unrank  = (r_cmd == CMD_UNRANK);
        o_sts.m_zero     = (r_m == 5'd0);
        o_sts.cnt_eq_occ = (r_cnt == r_occ);
        o_sts.rem_zero   = (r_rem == 6'd0);
        o_sts.bad        = r_bad;
        o_sts.step_stop  = (r_rd == DIM_SAT) || (r_hash < r_rd);
        o_sts.out_free   = !r_ovalid || !i_stall;
        o_prdata = (i_cfg.idx == REG_NUM_PARTICLES) ? {26'd0, r_par} : {27'd0, r_orb};
        o_valid     = r_ovalid;
        o_occ_out   = r_oocc;
        o_index_out = r_oidx;
        o_last      = r_olast;
        o_status    = r_ostat;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/oru_checker.sv =====
// ----------------------------------------------------------------------------
// oru_checker
// Port-level checks of the occupation rank/unrank block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "occupation_rank_unrank_top_macros.svh"
module oru_checker import oru_pkg::*; (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [31:0] o_index_out,
    input wire        o_last,
    input wire [1:0]  o_status
);

    `ORU_ASSERT_RST(a_reset_no_result, !i_rst_n, !o_valid)
    `ORU_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `ORU_ASSERT_NXT(a_result_held, o_valid && i_stall, o_valid && $stable(o_index_out))
    `ORU_ASSERT_IMP(a_err_no_index, o_valid && o_status != ST_OK, o_index_out == 32'd0)
    `ORU_ASSERT_IMP(a_sum_err_last, o_valid && o_status == ST_SUM, o_last)

endmodule

bind occupation_rank_unrank_top oru_checker u_oru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_index_out (o_index_out),
    .o_last      (o_last),
    .o_status    (o_status)
);
`default_nettype wire
